[rtl/aiaf_pkg.sv]
package aiaf_pkg;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_MIN_ANGLE      = 3'd0;
    localparam cfg_index_t CFG_ZERO_BAND      = 3'd1;
    localparam cfg_index_t CFG_RELEASE_BAND   = 3'd2;
    localparam cfg_index_t CFG_MOVE_THRESHOLD = 3'd3;
    localparam cfg_index_t CFG_TIMEOUT_US     = 3'd4;

    localparam logic ACT_STARTUP = 1'b0;
    localparam logic ACT_UPDATE  = 1'b1;

    localparam logic [31:0] MIN_ANGLE_RST      = 32'd0;
    localparam logic [30:0] ZERO_BAND_RST      = 31'd1144;
    localparam logic [30:0] RELEASE_BAND_RST   = 31'd2288;
    localparam logic [30:0] MOVE_THRESHOLD_RST = 31'd6554;
    localparam logic [31:0] TIMEOUT_US_RST     = 32'd5000000;

    // 180/pi as an unsigned fraction with 24 fractional bits.
    localparam logic [29:0] DEG_GAIN  = 30'd961263669;
    localparam int          DEG_SHIFT = 24;

    typedef struct packed {
        logic               action;
        logic               abs_updated;
        logic               inc_updated;
        logic               abs_valid;
        logic               inc_valid;
        logic signed [31:0] abs_angle;
        logic signed [31:0] inc_angle;
        logic signed [31:0] abs_velocity;
        logic signed [31:0] inc_velocity;
        logic [15:0]        abs_errors;
        logic [15:0]        inc_errors;
        logic [31:0]        time_us;
    } aiaf_in_t;

    typedef struct packed {
        logic               updated;
        logic               valid_res;
        logic signed [31:0] position_rad;
        logic signed [31:0] position_deg;
        logic signed [31:0] velocity_rad;
        logic signed [31:0] velocity_deg;
        logic [31:0]        stamp_us;
        logic [16:0]        error_total;
    } aiaf_out_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // Radians to degrees, rounded half away from zero, saturated to 32 bits.
    function automatic logic [31:0] to_degrees(input logic [31:0] rad);
        logic [31:0] mag;
        logic [61:0] prod;
        logic [37:0] rnd;
        mag  = mag32(rad);
        prod = 62'(mag) * 62'(DEG_GAIN);
        rnd  = 38'((prod + (62'd1 << (DEG_SHIFT - 1))) >> DEG_SHIFT);
        if (rad[31])
        begin
            if (rnd > 38'h0080000000)
            begin
                rnd = 38'h0080000000;
            end
            return 32'd0 - rnd[31:0];
        end
        if (rnd > 38'h007FFFFFFF)
        begin
            return 32'h7FFFFFFF;
        end
        return rnd[31:0];
    endfunction

endpackage

[rtl/absolute_incremental_angle_fusion.sv]
// Fuses an absolute angle sensor with a multi-turn quadrature count.
// Sample channel: sample_valid/sample_ready carry one aiaf_in_t per
// transaction, either a startup capture or a regular update.
// Result channel: result_valid/result_ready carry one aiaf_out_t for every
// sample transaction, in order, with angle and velocity in Q16.16 radians
// and saturated Q16.16 degrees.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (min angle, zero band, release band, move threshold, timeout);
// it is meant to be written only while no transaction is in flight.
// A sample passes three registers in order on its way to result_valid: the
// input register on acceptance, the fusion state registers, and the result
// register through the degree conversion.
// Throughput is one transaction per cycle. When the receiver stalls, the
// three stages fill and sample_ready then drops until the result is taken.
// Reset clears all stages, the fusion state and loads the default
// configuration.
module absolute_incremental_angle_fusion (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  aiaf_pkg::cfg_index_t cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  aiaf_pkg::aiaf_in_t   sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output aiaf_pkg::aiaf_out_t  result
);
    import aiaf_pkg::*;

    logic [31:0] min_angle_reg;
    logic [30:0] zero_band_reg;
    logic [30:0] release_band_reg;
    logic [30:0] move_threshold_reg;
    logic [31:0] timeout_us_reg;

    logic        s1_valid_reg;
    aiaf_in_t    s1_reg;
    logic        mid_valid_reg;
    logic        mid_updated_reg;
    logic        result_valid_reg;
    aiaf_out_t   result_reg;

    logic        zero_reg,      zero_next;
    logic        moved_reg,     moved_next;
    logic        locked_reg,    locked_next;
    logic [31:0] offset_reg,    offset_next;
    logic [31:0] start_pos_reg, start_pos_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] angle_reg,     angle_next;
    logic [31:0] velocity_reg,  velocity_next;
    logic        valid_reg,     valid_next;
    logic [31:0] stamp_reg,     stamp_next;
    logic [16:0] err_reg,       err_next;
    logic        updated_next;

    logic        out_adv;
    logic        s1_fire;
    logic [31:0] abs_mag;
    logic [32:0] travel;
    logic [32:0] travel_mag;
    logic [31:0] elapsed;
    logic        hit;

    assign out_adv      = !result_valid_reg || result_ready;
    assign s1_fire      = s1_valid_reg && (!mid_valid_reg || out_adv);
    assign sample_ready = !s1_valid_reg || s1_fire;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign abs_mag    = mag32(32'(s1_reg.abs_angle));
    assign travel     = {s1_reg.inc_angle[31], 32'(s1_reg.inc_angle)}
                        - {start_pos_reg[31], start_pos_reg};
    assign travel_mag = travel[32] ? (33'd0 - travel) : travel;
    assign elapsed    = s1_reg.time_us - start_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg      <= MIN_ANGLE_RST;
            zero_band_reg      <= ZERO_BAND_RST;
            release_band_reg   <= RELEASE_BAND_RST;
            move_threshold_reg <= MOVE_THRESHOLD_RST;
            timeout_us_reg     <= TIMEOUT_US_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_ANGLE:      min_angle_reg      <= cfg_data;
                CFG_ZERO_BAND:      zero_band_reg      <= cfg_data[30:0];
                CFG_RELEASE_BAND:   release_band_reg   <= cfg_data[30:0];
                CFG_MOVE_THRESHOLD: move_threshold_reg <= cfg_data[30:0];
                CFG_TIMEOUT_US:     timeout_us_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        zero_next       = zero_reg;
        moved_next      = moved_reg;
        locked_next     = locked_reg;
        offset_next     = offset_reg;
        start_pos_next  = start_pos_reg;
        start_time_next = start_time_reg;
        angle_next      = angle_reg;
        velocity_next   = velocity_reg;
        valid_next      = valid_reg;
        stamp_next      = stamp_reg;
        err_next        = err_reg;
        updated_next    = 1'b0;
        hit             = 1'b0;
        if (s1_reg.action == ACT_STARTUP)
        begin
            valid_next      = 1'b0;
            locked_next     = 1'b0;
            zero_next       = 1'b0;
            moved_next      = 1'b0;
            stamp_next      = s1_reg.time_us;
            start_time_next = s1_reg.time_us;
            err_next        = 17'd0;
            if (s1_reg.abs_valid && (abs_mag < {1'b0, zero_band_reg}))
            begin
                zero_next      = 1'b1;
                start_pos_next = 32'(s1_reg.inc_angle);
            end
        end
        else if (s1_reg.abs_updated || s1_reg.inc_updated)
        begin
            if (zero_reg && !moved_reg && s1_reg.inc_valid
                && (travel_mag > {2'b00, move_threshold_reg}))
            begin
                moved_next = 1'b1;
            end
            if (zero_reg && !locked_reg && (elapsed > timeout_us_reg))
            begin
                locked_next = 1'b1;
                offset_next = min_angle_reg - 32'(s1_reg.inc_angle);
            end
            if (!locked_next && s1_reg.abs_valid && s1_reg.inc_valid
                && (!zero_reg || (moved_next && (abs_mag > {1'b0, release_band_reg}))))
            begin
                locked_next = 1'b1;
                offset_next = 32'(s1_reg.abs_angle) - 32'(s1_reg.inc_angle);
            end
            if (locked_next && s1_reg.inc_valid)
            begin
                angle_next    = 32'(s1_reg.inc_angle) + offset_next;
                velocity_next = 32'(s1_reg.inc_velocity);
                hit           = 1'b1;
            end
            else if (s1_reg.abs_valid && !zero_reg)
            begin
                angle_next    = 32'(s1_reg.abs_angle);
                velocity_next = 32'(s1_reg.abs_velocity);
                hit           = 1'b1;
            end
            else if (s1_reg.inc_valid)
            begin
                angle_next    = min_angle_reg + (32'(s1_reg.inc_angle) - start_pos_reg);
                velocity_next = 32'(s1_reg.inc_velocity);
                hit           = 1'b1;
            end
            if (hit)
            begin
                valid_next   = 1'b1;
                stamp_next   = s1_reg.time_us;
                err_next     = 17'(s1_reg.abs_errors) + 17'(s1_reg.inc_errors);
                updated_next = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            mid_valid_reg    <= 1'b0;
            mid_updated_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            zero_reg         <= 1'b0;
            moved_reg        <= 1'b0;
            locked_reg       <= 1'b0;
            offset_reg       <= 32'd0;
            start_pos_reg    <= 32'd0;
            start_time_reg   <= 32'd0;
            angle_reg        <= 32'd0;
            velocity_reg     <= 32'd0;
            valid_reg        <= 1'b0;
            stamp_reg        <= 32'd0;
            err_reg          <= 17'd0;
        end
        else
        begin
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s1_fire)
            begin
                mid_valid_reg   <= 1'b1;
                mid_updated_reg <= updated_next;
                zero_reg        <= zero_next;
                moved_reg       <= moved_next;
                locked_reg      <= locked_next;
                offset_reg      <= offset_next;
                start_pos_reg   <= start_pos_next;
                start_time_reg  <= start_time_next;
                angle_reg       <= angle_next;
                velocity_reg    <= velocity_next;
                valid_reg       <= valid_next;
                stamp_reg       <= stamp_next;
                err_reg         <= err_next;
            end
            else if (out_adv)
            begin
                mid_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                result_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            s1_reg <= sample;
        end
        if (out_adv && mid_valid_reg)
        begin
            result_reg.updated      <= mid_updated_reg;
            result_reg.valid_res    <= valid_reg;
            result_reg.position_rad <= angle_reg;
            result_reg.position_deg <= to_degrees(angle_reg);
            result_reg.velocity_rad <= velocity_reg;
            result_reg.velocity_deg <= to_degrees(velocity_reg);
            result_reg.stamp_us     <= stamp_reg;
            result_reg.error_total  <= err_reg;
        end
    end

`ifndef ASSERT_OFF
    a_moved_needs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        moved_reg |-> zero_reg)
        else $error("Movement flag set without a zero start.");

    a_updated_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.updated || result_reg.valid_res))
        else $error("Updated result reported as invalid.");

    a_startup_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_reg.action == ACT_STARTUP))
        |=> (!locked_reg && !moved_reg && !valid_reg && (err_reg == 17'd0)))
        else $error("Startup transaction did not clear the fusion flags.");
`endif

endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aiaf_pkg::*;

    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        aiaf_in_t  stim;
        bit        pinned;
        aiaf_out_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = CFG_MIN_ANGLE;
    logic [31:0] cfg_data = '0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    aiaf_in_t    sample = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    aiaf_out_t   result;

    // Register copies and fusion state of the predictor.
    logic [31:0]        reg_min_angle = MIN_ANGLE_RST;
    logic [30:0]        reg_zero_band = ZERO_BAND_RST;
    logic [30:0]        reg_release_band = RELEASE_BAND_RST;
    logic [30:0]        reg_move_threshold = MOVE_THRESHOLD_RST;
    logic [31:0]        reg_timeout_us = TIMEOUT_US_RST;
    logic               st_zero_start = 1'b0;
    logic               st_moved = 1'b0;
    logic               st_locked = 1'b0;
    logic [31:0]        st_offset = '0;
    logic signed [31:0] st_start_pos = '0;
    logic [31:0]        st_start_time = '0;
    logic [31:0]        st_angle = '0;
    logic [31:0]        st_velocity = '0;
    logic               st_valid = 1'b0;
    logic [31:0]        st_stamp = '0;
    logic [16:0]        st_err_sum = '0;

    aiaf_out_t pending_results[$];
    plan_row_t plan[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        startups_sent = 0;
    int        fresh_seen = 0;
    int        cycle_count = 0;
    bit        sender_quiet = 1'b0;
    int        sender_left = 0;

    absolute_incremental_angle_fusion u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic longint magnitude_of(input logic signed [31:0] v);
        longint w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic [31:0] rad_to_deg(input logic signed [31:0] v);
        longint unsigned m;
        longint unsigned p;
        m = v[31] ? 64'(-longint'(v)) : 64'(v);
        p = (m * 64'(DEG_GAIN) + (64'd1 << (DEG_SHIFT - 1))) >> DEG_SHIFT;
        if (!v[31])
        begin
            return (p > 64'h7FFFFFFF) ? 32'h7FFFFFFF : p[31:0];
        end
        return (p > 64'h80000000) ? 32'h80000000 : 32'(64'd0 - p);
    endfunction

    function automatic logic [31:0] with_random_sign(input logic [31:0] m);
        return ($urandom_range(0, 1) != 0) ? 32'd0 - m : m;
    endfunction

    function automatic aiaf_in_t rand_sample();
        aiaf_in_t s;
        s.action       = 1'($urandom_range(0, 1));
        s.abs_updated  = 1'($urandom_range(0, 1));
        s.inc_updated  = 1'($urandom_range(0, 1));
        s.abs_valid    = 1'($urandom_range(0, 1));
        s.inc_valid    = 1'($urandom_range(0, 1));
        s.abs_angle    = $urandom();
        s.inc_angle    = $urandom();
        s.abs_velocity = $urandom();
        s.inc_velocity = $urandom();
        s.abs_errors   = 16'($urandom());
        s.inc_errors   = 16'($urandom());
        s.time_us      = $urandom();
        return s;
    endfunction

    task automatic fuse_sample(input aiaf_in_t s, output aiaf_out_t o);
        logic   fresh;
        longint travel;
        fresh = 1'b0;
        if (s.action == ACT_STARTUP)
        begin
            st_valid = 1'b0;
            st_locked = 1'b0;
            st_zero_start = 1'b0;
            st_moved = 1'b0;
            st_stamp = s.time_us;
            st_start_time = s.time_us;
            st_err_sum = '0;
            if (s.abs_valid && magnitude_of(s.abs_angle) < longint'(reg_zero_band))
            begin
                st_zero_start = 1'b1;
                st_start_pos = s.inc_angle;
            end
        end
        else if (s.abs_updated || s.inc_updated)
        begin
            if (st_zero_start && !st_moved && s.inc_valid)
            begin
                travel = longint'(s.inc_angle) - longint'(st_start_pos);
                if (travel < 0)
                begin
                    travel = -travel;
                end
                if (travel > longint'(reg_move_threshold))
                begin
                    st_moved = 1'b1;
                end
            end
            if (st_zero_start && !st_locked && (s.time_us - st_start_time) > reg_timeout_us)
            begin
                st_locked = 1'b1;
                st_offset = reg_min_angle - s.inc_angle;
            end
            if (!st_locked && s.abs_valid && s.inc_valid && (!st_zero_start ||
                (st_moved && magnitude_of(s.abs_angle) > longint'(reg_release_band))))
            begin
                st_offset = s.abs_angle - s.inc_angle;
                st_locked = 1'b1;
            end
            fresh = 1'b1;
            if (st_locked && s.inc_valid)
            begin
                st_angle = s.inc_angle + st_offset;
                st_velocity = s.inc_velocity;
            end
            else if (s.abs_valid && !st_zero_start)
            begin
                st_angle = s.abs_angle;
                st_velocity = s.abs_velocity;
            end
            else if (s.inc_valid)
            begin
                st_angle = reg_min_angle + (s.inc_angle - st_start_pos);
                st_velocity = s.inc_velocity;
            end
            else
            begin
                st_valid = 1'b0;
                fresh = 1'b0;
            end
            if (fresh)
            begin
                st_valid = 1'b1;
                st_stamp = s.time_us;
                st_err_sum = 17'(s.abs_errors) + 17'(s.inc_errors);
            end
        end
        o.updated      = fresh;
        o.valid_res    = st_valid;
        o.position_rad = st_angle;
        o.position_deg = rad_to_deg(st_angle);
        o.velocity_rad = st_velocity;
        o.velocity_deg = rad_to_deg(st_velocity);
        o.stamp_us     = st_stamp;
        o.error_total  = st_err_sum;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_MIN_ANGLE:      reg_min_angle = data;
            CFG_ZERO_BAND:      reg_zero_band = data[30:0];
            CFG_RELEASE_BAND:   reg_release_band = data[30:0];
            CFG_MOVE_THRESHOLD: reg_move_threshold = data[30:0];
            CFG_TIMEOUT_US:     reg_timeout_us = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_sample(input aiaf_in_t s, input bit pinned, input aiaf_out_t want);
        int        gap;
        aiaf_out_t predicted;
        if (sender_left == 0)
        begin
            sender_quiet = ($urandom_range(0, 2) == 0);
            sender_left = $urandom_range(20, 60);
        end
        sender_left--;
        gap = sender_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample <= s;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
        fuse_sample(s, predicted);
        pending_results.push_back(pinned ? want : predicted);
        items_sent++;
        if (s.action == ACT_STARTUP)
        begin
            startups_sent++;
        end
        @(negedge clk);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Startup followed by a run of updates along a drifting quadrature path,
    // with some transactions of pure noise mixed in.
    task automatic run_episodes(input int count);
        aiaf_in_t    s;
        int          sent;
        int          span;
        bit          dir;
        logic [31:0] now;
        logic [31:0] pos;
        logic [31:0] mag;
        logic [31:0] cap;
        longint      far;
        sent = 0;
        while (sent < count)
        begin
            s = rand_sample();
            if ($urandom_range(0, 11) == 0)
            begin
                push_sample(s, 1'b0, '0);
                sent++;
                continue;
            end
            s.action = ACT_STARTUP;
            if ($urandom_range(0, 3) != 0 && reg_zero_band != 0)
            begin
                s.abs_valid = 1'b1;
                s.abs_angle = with_random_sign($urandom_range(0, 32'(reg_zero_band) - 1));
            end
            if ($urandom_range(0, 1) != 0)
            begin
                s.inc_angle = with_random_sign($urandom_range(0, 32'hFFFF));
            end
            now = s.time_us;
            pos = s.inc_angle;
            dir = 1'($urandom_range(0, 1));
            push_sample(s, 1'b0, '0);
            sent++;
            span = $urandom_range(3, 40);
            cap = (reg_move_threshold > 31'h1FFFFFFF) ? 32'h1FFFFFFF : 32'(reg_move_threshold);
            while (span > 0 && sent < count)
            begin
                s = rand_sample();
                s.action = ACT_UPDATE;
                case ($urandom_range(0, 7))
                    0:       now = now + $urandom();
                    1:       now = now + $urandom_range(0, reg_timeout_us / 2 + 1);
                    default: now = now + $urandom_range(0, 5000);
                endcase
                mag = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, cap / 4 + 64);
                pos = (($urandom_range(0, 4) == 0) ^ dir) ? pos - mag : pos + mag;
                case ($urandom_range(0, 2))
                    0:
                    begin
                        s.abs_angle = with_random_sign($urandom_range(0, 32'(reg_release_band)));
                    end
                    1:
                    begin
                        far = longint'(reg_release_band) + 1 + $urandom_range(0, 32'hFFFF);
                        s.abs_angle = (far > 64'h7FFFFFFF) ? 32'h80000000
                                                            : with_random_sign(32'(far));
                    end
                    default: ;
                endcase
                case ($urandom_range(0, 9))
                    0:       {s.abs_updated, s.inc_updated} = 2'b00;
                    1:       {s.abs_updated, s.inc_updated} = 2'b10;
                    2:       {s.abs_updated, s.inc_updated} = 2'b01;
                    default: {s.abs_updated, s.inc_updated} = 2'b11;
                endcase
                s.abs_valid = ($urandom_range(0, 7) != 0);
                s.inc_valid = ($urandom_range(0, 7) != 0);
                s.time_us = now;
                s.inc_angle = pos;
                push_sample(s, 1'b0, '0);
                sent++;
                span--;
                if ($urandom_range(0, 149) == 0)
                begin
                    settle();
                end
            end
        end
    endtask

    task automatic check_result(input aiaf_out_t want, input aiaf_out_t got);
        if (got.updated !== want.updated)
        begin
            $error("updated: expected %0h, got %0h", want.updated, got.updated);
            mismatches++;
        end
        if (got.valid_res !== want.valid_res)
        begin
            $error("valid_res: expected %0h, got %0h", want.valid_res, got.valid_res);
            mismatches++;
        end
        if (got.position_rad !== want.position_rad)
        begin
            $error("position_rad: expected %0h, got %0h", want.position_rad, got.position_rad);
            mismatches++;
        end
        if (got.position_deg !== want.position_deg)
        begin
            $error("position_deg: expected %0h, got %0h", want.position_deg, got.position_deg);
            mismatches++;
        end
        if (got.velocity_rad !== want.velocity_rad)
        begin
            $error("velocity_rad: expected %0h, got %0h", want.velocity_rad, got.velocity_rad);
            mismatches++;
        end
        if (got.velocity_deg !== want.velocity_deg)
        begin
            $error("velocity_deg: expected %0h, got %0h", want.velocity_deg, got.velocity_deg);
            mismatches++;
        end
        if (got.stamp_us !== want.stamp_us)
        begin
            $error("stamp_us: expected %0h, got %0h", want.stamp_us, got.stamp_us);
            mismatches++;
        end
        if (got.error_total !== want.error_total)
        begin
            $error("error_total: expected %0h, got %0h", want.error_total, got.error_total);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction arrived with nothing expected");
                mismatches++;
            end
            else
            begin
                check_result(pending_results.pop_front(), result);
            end
            if (result.updated)
            begin
                fresh_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int stall;
        int left;
        bit quiet;
        left = 0;
        quiet = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (left == 0)
            begin
                quiet = ($urandom_range(0, 2) == 0);
                left = $urandom_range(20, 60);
            end
            left--;
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b0, 1'b0, 1'b1, 1'b1, 32'h7FFFFFFF,
            32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF}, 1'b1,
            aiaf_out_t'{1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0}});
        plan.push_back('{aiaf_in_t'{ACT_STARTUP, 1'b1, 1'b1, 1'b1, 1'b1, 32'h00100000,
            32'hFFFFFFFF, 32'h1234, 32'h5678, 16'hFFFF, 16'hFFFF, 32'd100}, 1'b1,
            aiaf_out_t'{1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd100, 17'h0}});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b1, 1'b1, 1'b1, 32'h00010000,
            32'h00030000, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 32'd200}, 1'b1,
            aiaf_out_t'{1'b1, 1'b1, 32'h00010000, 32'd3754936, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'd200, 17'h1FFFE}});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0, 32'h0,
            32'h80000000, 16'h0, 16'h0, 32'd300}, 1'b1,
            aiaf_out_t'{1'b1, 1'b1, 32'hFFFE0000, 32'hFF8D6890, 32'h80000000, 32'h80000000,
            32'd300, 17'h0}});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b1, 1'b0, 1'b0, 32'h00020000,
            32'h00040000, 32'h1, 32'h2, 16'h1, 16'h2, 32'd400}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_STARTUP, 1'b0, 1'b0, 1'b1, 1'b1, 32'd1144, 32'd5,
            32'h0, 32'h0, 16'h0, 16'h0, 32'd500}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b0, 1'b1, 1'b0, 32'h80000000,
            32'h10, 32'h7FFFFFFF, 32'h0, 16'h8000, 16'h1, 32'd600}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_STARTUP, 1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFFFB89,
            32'h00012345, 32'h0, 32'h0, 16'h0, 16'h0, 32'd1000}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0, 32'h000123A9,
            32'h0, 32'h1000, 16'h3, 16'h4, 32'd1100}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b1, 1'b1, 1'b1, 32'd2288,
            32'h00013CE0, 32'h0, 32'hFFFFF000, 16'h5, 16'h6, 32'd1200}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFFF70F,
            32'h00013CE0, 32'h100, 32'h200, 16'h7, 16'h8, 32'd1300}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_STARTUP, 1'b0, 1'b0, 1'b1, 1'b1, 32'h0, 32'h7FFFFFF0,
            32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFFFF00}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b0, 1'b1, 1'b0, 32'h00100000,
            32'h7FFFFFF0, 32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFFFF00 + 32'd5000000}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b0, 1'b1, 1'b0, 32'h00100000,
            32'h80000000, 32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFFFF00 + 32'd5000001}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0, 32'h80000010,
            32'h0, 32'hFFFFFFFF, 16'hFFFF, 16'h0, 32'hFFFFFF00 + 32'd5000002}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_STARTUP, 1'b1, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0, 32'h0,
            32'h0, 16'h0, 16'h0, 32'd2000}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b1, 1'b1, 1'b1, 32'h7FFFFFFF,
            32'h80000000, 32'h7FFFFFFF, 32'h80000001, 16'hFFFF, 16'hFFFF, 32'd2100}, 1'b0, '0});
        plan.push_back('{aiaf_in_t'{ACT_UPDATE, 1'b1, 1'b0, 1'b1, 1'b1, 32'h80000000,
            32'h80000000, 32'h0, 32'h0, 16'h0, 16'h0, 32'd2200}, 1'b0, '0});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            push_sample(plan[i].stim, plan[i].pinned, plan[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                settle();
                case (phase)
                    1:
                    begin
                        write_reg(CFG_MIN_ANGLE, 32'h7FFFFFFF);
                        write_reg(CFG_ZERO_BAND, 32'hFFFFFFFF);
                        write_reg(CFG_RELEASE_BAND, 32'h80000000);
                        write_reg(CFG_MOVE_THRESHOLD, 32'h0);
                        write_reg(CFG_TIMEOUT_US, 32'h0);
                        write_reg(cfg_index_t'(CFG_TIMEOUT_US + 3'd1), $urandom());
                    end
                    2:
                    begin
                        write_reg(CFG_MIN_ANGLE, 32'h80000000);
                        write_reg(CFG_ZERO_BAND, 32'h0);
                        write_reg(CFG_RELEASE_BAND, 32'h7FFFFFFF);
                        write_reg(CFG_MOVE_THRESHOLD, 32'hFFFFFFFF);
                        write_reg(CFG_TIMEOUT_US, 32'hFFFFFFFF);
                    end
                    default:
                    begin
                        write_reg(CFG_MIN_ANGLE, $urandom());
                        write_reg(CFG_ZERO_BAND, {1'($urandom_range(0, 1)),
                                                  31'($urandom_range(0, 32'h4000))});
                        write_reg(CFG_RELEASE_BAND, {1'($urandom_range(0, 1)),
                                                     31'($urandom_range(0, 32'h8000))});
                        write_reg(CFG_MOVE_THRESHOLD, {1'($urandom_range(0, 1)),
                                                       31'($urandom_range(0, 32'h20000))});
                        write_reg(CFG_TIMEOUT_US, $urandom_range(0, 400000));
                    end
                endcase
            end
            run_episodes(ITEMS_PER_PHASE);
        end

        settle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d sample transactions, %0d of them startups, under %0d settings.",
                 items_sent, startups_sent, PHASES);
        $display("%0d results carried a fresh fused reading; %0d field mismatches were seen.",
                 fresh_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
